>>> src/dct2d_pkg.sv
// Shared types, constants and coefficient helpers for the 2-D integer DCT unit.
package dct2d_pkg;

  localparam int MAX_POINTS_DEF = 8;
  localparam int CNT_W          = 3;
  localparam int ADDR_W_MAX     = 6;
  localparam int LOAD_W         = 7;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 8;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int ACC_W          = 27;
  localparam int SHIFT_W        = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE      = 2'd1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_ACC,
    S_WR,
    S_EMIT_RD,
    S_EMIT_WAIT
  } dct2d_state_t;

  typedef struct packed {
    logic                      load_we;
    logic                      rd_a;
    logic                      rd_b;
    logic [ADDR_W_MAX-1:0]     rd_addr;
    logic                      acc_en;
    logic                      acc_first;
    logic signed [COEF_W-1:0]  coef;
    logic                      wr_a;
    logic                      wr_b;
    logic [ADDR_W_MAX-1:0]     wr_addr;
    logic                      col_pass;
    logic                      inverse;
    logic                      n8;
  } dct2d_cmd_t;

  // 8-point core matrix, row k is basis function k
  localparam logic signed [COEF_W-1:0] C8 [8][8] = '{
    '{ 8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64,  8'sd64},
    '{ 8'sd89,  8'sd75,  8'sd50,  8'sd18, -8'sd18, -8'sd50, -8'sd75, -8'sd89},
    '{ 8'sd83,  8'sd36, -8'sd36, -8'sd83, -8'sd83, -8'sd36,  8'sd36,  8'sd83},
    '{ 8'sd75, -8'sd18, -8'sd89, -8'sd50,  8'sd50,  8'sd89,  8'sd18, -8'sd75},
    '{ 8'sd64, -8'sd64, -8'sd64,  8'sd64,  8'sd64, -8'sd64, -8'sd64,  8'sd64},
    '{ 8'sd50, -8'sd89,  8'sd18,  8'sd75, -8'sd75, -8'sd18,  8'sd89, -8'sd50},
    '{ 8'sd36, -8'sd83,  8'sd83, -8'sd36, -8'sd36,  8'sd83, -8'sd83,  8'sd36},
    '{ 8'sd18, -8'sd50,  8'sd75, -8'sd89,  8'sd89, -8'sd75,  8'sd50, -8'sd18}
  };

  // 4-point matrix is the even rows of the 8-point one, first four columns
  function automatic logic signed [COEF_W-1:0] coef_of(input logic n8,
                                                       input logic [CNT_W-1:0] k,
                                                       input logic [CNT_W-1:0] m);
    logic [CNT_W-1:0] row;
    row = n8 ? k : {k[1:0], 1'b0};
    return C8[row][m];
  endfunction

  function automatic logic [ADDR_W_MAX-1:0] blk_addr(input logic n8,
                                                     input logic [CNT_W-1:0] r,
                                                     input logic [CNT_W-1:0] c);
    return n8 ? {r, c} : {2'b00, r[1:0], c[1:0]};
  endfunction

endpackage

>>> src/dct2d_dp.sv
// Datapath: sample store, intermediate store, multiply-accumulate, shift and clamp.
module dct2d_dp #(
  parameter int MAX_POINTS = dct2d_pkg::MAX_POINTS_DEF
) (
  input  logic                                    clk,
  input  dct2d_pkg::dct2d_cmd_t                   cmd,
  input  logic signed [dct2d_pkg::SAMPLE_W-1:0]   sample,
  output logic signed [dct2d_pkg::SAMPLE_W-1:0]   value
);
  import dct2d_pkg::*;

  localparam int DEPTH = MAX_POINTS * MAX_POINTS;
  localparam int AW    = $clog2(DEPTH);

  logic signed [SAMPLE_W-1:0] mem_a [DEPTH];
  logic signed [SAMPLE_W-1:0] mem_b [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_a_data;
  logic signed [SAMPLE_W-1:0] rd_b_data;
  logic signed [SAMPLE_W-1:0] operand;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    shifted;
  logic signed [ACC_W-1:0]    lo;
  logic signed [ACC_W-1:0]    hi;
  logic signed [SAMPLE_W-1:0] clamped;
  logic [SHIFT_W-1:0]         sh;

  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem_a[cmd.wr_addr[AW-1:0]] <= sample;
    end else if (cmd.wr_a) begin
      mem_a[cmd.wr_addr[AW-1:0]] <= clamped;
    end
    if (cmd.rd_a) begin
      rd_a_data <= mem_a[cmd.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      mem_b[cmd.wr_addr[AW-1:0]] <= clamped;
    end
    if (cmd.rd_b) begin
      rd_b_data <= mem_b[cmd.rd_addr[AW-1:0]];
    end
  end

  assign operand = cmd.col_pass ? rd_b_data : rd_a_data;
  assign prod    = operand * cmd.coef;

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      acc <= cmd.acc_first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  always_comb begin
    if (cmd.inverse) begin
      sh = cmd.col_pass ? SHIFT_W'(12) : SHIFT_W'(7);
    end else if (cmd.n8) begin
      sh = cmd.col_pass ? SHIFT_W'(9) : SHIFT_W'(2);
    end else begin
      sh = cmd.col_pass ? SHIFT_W'(8) : SHIFT_W'(1);
    end
    shifted = acc >>> sh;
    if (cmd.col_pass && cmd.inverse && !cmd.n8) begin
      lo = ACC_W'(0);
      hi = ACC_W'(255);
    end else begin
      lo = -ACC_W'(32768);
      hi = ACC_W'(32767);
    end
    if (shifted < lo) begin
      clamped = lo[SAMPLE_W-1:0];
    end else if (shifted > hi) begin
      clamped = hi[SAMPLE_W-1:0];
    end else begin
      clamped = shifted[SAMPLE_W-1:0];
    end
  end

  // emitted value is the held read data of the sample store
  assign value = rd_a_data;

endmodule

>>> src/dct2d_ctrl.sv
// Controller: configuration registers, load counter and pass sequencer.
module dct2d_ctrl #(
  parameter int MAX_POINTS = dct2d_pkg::MAX_POINTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dct2d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dct2d_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                last,
  output dct2d_pkg::dct2d_cmd_t               cmd
);
  import dct2d_pkg::*;

  dct2d_state_t     state, state_next;
  logic             direction, size_select;
  logic             inverse, inverse_next;
  logic             n8, n8_next;
  logic             col_pass, col_pass_next;
  logic [LOAD_W-1:0] load_count, load_count_next;
  logic [CNT_W-1:0] u, u_next;
  logic [CNT_W-1:0] i, i_next;
  logic [CNT_W-1:0] j, j_next;
  logic             n8_cfg;
  logic [CNT_W-1:0] top_idx;
  logic [LOAD_W-1:0] load_top;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      size_select <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIRECTION: direction   <= cfg_data[0];
        REG_SIZE:      size_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign n8_cfg   = size_select && (MAX_POINTS >= 8);
  assign load_top = n8_cfg ? LOAD_W'(63) : LOAD_W'(15);
  assign top_idx  = n8 ? CNT_W'(7) : CNT_W'(3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      inverse    <= 1'b0;
      n8         <= 1'b0;
      col_pass   <= 1'b0;
      u          <= '0;
      i          <= '0;
      j          <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
      inverse    <= inverse_next;
      n8         <= n8_next;
      col_pass   <= col_pass_next;
      u          <= u_next;
      i          <= i_next;
      j          <= j_next;
    end
  end

  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    inverse_next    = inverse;
    n8_next         = n8;
    col_pass_next   = col_pass;
    u_next          = u;
    i_next          = i;
    j_next          = j;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd             = '0;
    cmd.col_pass    = col_pass;
    cmd.inverse     = inverse;
    cmd.n8          = n8;
    cmd.coef        = inverse ? coef_of(n8, j, i) : coef_of(n8, i, j);
    last            = (u == top_idx) && (i == top_idx);
    case (state)
      S_LOAD: begin
        in_ready    = 1'b1;
        cmd.wr_addr = load_count[ADDR_W_MAX-1:0];
        if (in_valid) begin
          cmd.load_we = 1'b1;
          // a size drop mid-load can leave the count past the new block end
          if (load_count >= load_top) begin
            load_count_next = '0;
            inverse_next    = direction;
            n8_next         = n8_cfg;
            col_pass_next   = 1'b0;
            u_next          = '0;
            i_next          = '0;
            j_next          = '0;
            state_next      = S_RD;
          end else begin
            load_count_next = load_count + LOAD_W'(1);
          end
        end
      end
      S_RD: begin
        // row pass reads row u of the samples, column pass reads column u of the intermediate store
        if (col_pass) begin
          cmd.rd_b    = 1'b1;
          cmd.rd_addr = blk_addr(n8, j, u);
        end else begin
          cmd.rd_a    = 1'b1;
          cmd.rd_addr = blk_addr(n8, u, j);
        end
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_first = (j == '0);
        if (j == top_idx) begin
          state_next = S_WR;
        end else begin
          j_next     = j + CNT_W'(1);
          state_next = S_RD;
        end
      end
      S_WR: begin
        if (col_pass) begin
          cmd.wr_a    = 1'b1;
          cmd.wr_addr = blk_addr(n8, i, u);
        end else begin
          cmd.wr_b    = 1'b1;
          cmd.wr_addr = blk_addr(n8, u, i);
        end
        j_next     = '0;
        state_next = S_RD;
        if (i == top_idx) begin
          i_next = '0;
          if (u == top_idx) begin
            u_next = '0;
            if (col_pass) begin
              col_pass_next = 1'b0;
              state_next    = S_EMIT_RD;
            end else begin
              col_pass_next = 1'b1;
            end
          end else begin
            u_next = u + CNT_W'(1);
          end
        end else begin
          i_next = i + CNT_W'(1);
        end
      end
      S_EMIT_RD: begin
        cmd.rd_a    = 1'b1;
        cmd.rd_addr = blk_addr(n8, u, i);
        state_next  = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_EMIT_RD;
          if (i == top_idx) begin
            i_next = '0;
            if (u == top_idx) begin
              u_next     = '0;
              state_next = S_LOAD;
            end else begin
              u_next = u + CNT_W'(1);
            end
          end else begin
            i_next = i + CNT_W'(1);
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> ($past(state) == S_RD))
    else $error("accumulate without a preceding read");

  a_wr_then_next: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |=> (state == S_RD || state == S_EMIT_RD))
    else $error("bad step after write-back");

  a_count_only_loading: assert property (@(posedge clk) disable iff (rst)
    (load_count != '0) |-> (state == S_LOAD))
    else $error("partial load outside load state");

endmodule

>>> src/integer_dct_2d_fwd_inv_unit.sv
// Top level of the 2-D forward/inverse integer DCT unit (4x4 and 8x8 blocks).
//
//   channel | direction | handshake            | payload
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in      | in        | in_valid/in_ready    | sample
//   out     | out       | out_valid/out_ready  | value, last
//
// Load takes one sample per cycle, then each pass runs its multiply-accumulates
// on the shared MAC, each a read state (S_RD) then an accumulate state (S_ACC),
// with a write-back state (S_WR) per result. Emit reads each result (S_EMIT_RD,
// one store read port) and holds it until out_ready. Input is held off from the
// last sample until the last result is taken. Reset (synchronous) clears the
// registers and load count; the sample store holds no reset value.
module integer_dct_2d_fwd_inv_unit #(
  parameter int MAX_POINTS = dct2d_pkg::MAX_POINTS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [dct2d_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dct2d_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [dct2d_pkg::SAMPLE_W-1:0]   sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [dct2d_pkg::SAMPLE_W-1:0]   value,
  output logic                                    last
);
  import dct2d_pkg::*;

  dct2d_cmd_t cmd;

  dct2d_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last),
    .cmd       (cmd)
  );

  dct2d_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .sample (sample),
    .value  (value)
  );

endmodule
